FILE: hdl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg: shared constants, types and helpers of the matrix multiply engine
// Fixed-point Q8.8 operands, exact wide accumulation, Q16.16 saturated results.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM  = 16;
  localparam int SIZE_CAP = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam int KW       = $clog2(MAX_DIM);
  localparam int AW       = $clog2(MAX_DIM * MAX_DIM);
  localparam int PROD_W   = 32;
  localparam int ACC_W    = PROD_W + 1 + $clog2(SIZE_CAP);
  localparam int SZ_W     = 5;

  localparam logic [1:0] OP_WR_A    = 2'd0;
  localparam logic [1:0] OP_WR_B    = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] CFG_A_ROWS = 2'd0;
  localparam logic [1:0] CFG_SHARED = 2'd1;
  localparam logic [1:0] CFG_B_COLS = 2'd2;

  localparam logic [SZ_W-1:0] SIZE_RESET = 5'd16;

  typedef struct packed {
    logic          valid;
    logic          first;
    logic [KW-1:0] k;
  } mme_tok_t;

  // zero counts as one, anything above the cap counts as the cap
  function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] r);
    if (r == '0) begin
      return SZ_W'(1);
    end else if (r > SZ_W'(SIZE_CAP)) begin
      return SZ_W'(SIZE_CAP);
    end else begin
      return r;
    end
  endfunction

  function automatic logic [AW-1:0] elem_addr(input logic [3:0] r,
                                               input logic [SZ_W-1:0] c);
    return AW'(AW'(r) * AW'(MAX_DIM) + AW'(c));
  endfunction

endpackage

FILE: hdl/mme_item_if.sv
// ----------------------------------------------------------------------------
// mme_item_if: command channel of the matrix multiply engine
// Element loads and row compute requests, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mme_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         row;
  logic [3:0]         col;
  logic signed [15:0] value;

  modport source (output valid, output op, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input op, input row, input col, input value,
                  output ready);
endinterface

FILE: hdl/mme_result_if.sv
// ----------------------------------------------------------------------------
// mme_result_if: result channel of the matrix multiply engine
// One beat per output column, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mme_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_col;
  logic signed [31:0] sum;
  logic               clipped;
  logic               last;

  modport source (output valid, output out_col, output sum, output clipped,
                  output last, input ready);
  modport sink   (input valid, input out_col, input sum, input clipped,
                  input last, output ready);
endinterface

FILE: hdl/mme_cfg_if.sv
// ----------------------------------------------------------------------------
// mme_cfg_if: register write channel of the matrix multiply engine
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mme_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/mme_cell.sv
// ----------------------------------------------------------------------------
// mme_cell: one output column of the product chain
// Holds one column of B, multiplies it with the passing A element and
// accumulates exactly; during drain the sums shift toward column zero.
// ----------------------------------------------------------------------------
module mme_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  mme_pkg::mme_tok_t                 in_tok,
  input  logic signed [15:0]                in_a,
  output mme_pkg::mme_tok_t                 out_tok,
  output logic signed [15:0]                out_a,
  input  logic                              b_we,
  input  logic [mme_pkg::KW-1:0]            b_addr,
  input  logic signed [15:0]                b_data,
  input  logic                              shift,
  input  logic signed [mme_pkg::ACC_W-1:0]  in_acc,
  output logic signed [mme_pkg::ACC_W-1:0]  acc
);

  logic signed [15:0]                 b_mem [mme_pkg::MAX_DIM];
  logic signed [15:0]                 b_q;
  logic signed [15:0]                 a_d;
  mme_pkg::mme_tok_t                  tok_d;
  mme_pkg::mme_tok_t                  tok_p;
  logic signed [mme_pkg::PROD_W-1:0]  prod;
  logic signed [mme_pkg::ACC_W-1:0]   acc_base;

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_addr] <= b_data;
    end
    b_q <= b_mem[in_tok.k];
  end

  always_ff @(posedge clk) begin
    a_d  <= in_a;
    prod <= a_d * b_q;
    if (rst) begin
      tok_d <= '0;
      tok_p <= '0;
    end else begin
      tok_d <= in_tok;
      tok_p <= tok_d;
    end
  end

  assign acc_base = tok_p.first ? '0 : acc;

  always_ff @(posedge clk) begin
    if (shift) begin
      acc <= in_acc;
    end else if (tok_p.valid) begin
      acc <= acc_base + mme_pkg::ACC_W'(prod);
    end
  end

  assign out_tok = tok_d;
  assign out_a   = a_d;

endmodule

FILE: hdl/matrix_multiply_engine_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top: fixed-point matrix product engine
// Stores A and B (Q8.8), computes one output row of A*B per request as a
// chain of column cells and streams saturated Q16.16 sums per column.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  items     in    valid/ready    op, row, col, value
//  results   out   valid/ready    out_col, sum, clipped, last
//  cfg       in    valid/ready    index, data (always ready)
//
//  a row compute streams A and the shared index through the cell chain,
//  waits for the last cell to settle, then drains one column beat per
//  cycle while results are taken.
//  items is held off from a compute request until its last beat is loaded.
//  a stalled results channel holds the drain; no beat is lost.
//  reset is synchronous; stores are not cleared and sizes return to 16.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_top (
  input  logic           clk,
  input  logic           rst,
  mme_item_if.sink       items,
  mme_result_if.source   results,
  mme_cfg_if.sink        cfg
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  localparam int WW        = $clog2(mme_pkg::MAX_DIM + 4);
  localparam int WAIT_LAST = mme_pkg::MAX_DIM + 3;

  logic [1:0]                     state;
  logic [3:0]                     row_q;
  logic [mme_pkg::SZ_W-1:0]       kn_q;
  logic [mme_pkg::SZ_W-1:0]       cols_q;
  logic [mme_pkg::SZ_W-1:0]       kcnt;
  logic [mme_pkg::SZ_W-1:0]       dcnt;
  logic [WW-1:0]                  wcnt;
  logic [mme_pkg::SZ_W-1:0]       a_rows;
  logic [mme_pkg::SZ_W-1:0]       k_size;
  logic [mme_pkg::SZ_W-1:0]       b_cols;

  logic signed [15:0]             a_mem [mme_pkg::MAX_DIM * mme_pkg::MAX_DIM];
  logic signed [15:0]             a_q;
  mme_pkg::mme_tok_t              tok_q;
  mme_pkg::mme_tok_t              tok_next;

  logic                           accept;
  logic                           in_store;
  logic                           wr_a;
  logic                           wr_b;
  logic                           comp_go;
  logic                           load;
  logic                           last_col;

  mme_pkg::mme_tok_t              tok_o [mme_pkg::MAX_DIM];
  logic signed [15:0]             a_o   [mme_pkg::MAX_DIM];
  logic signed [mme_pkg::ACC_W-1:0] acc_o [mme_pkg::MAX_DIM];

  logic [mme_pkg::ACC_W-32:0]     acc_hi;
  logic signed [31:0]             sat_sum;
  logic                           sat_clip;

  logic                           out_valid;
  logic [3:0]                     out_col;
  logic signed [31:0]             out_sum;
  logic                           out_clip;
  logic                           out_last;

  // handshake and decode
  assign items.ready = (state == ST_IDLE);
  assign accept      = items.valid && items.ready;
  assign in_store    = (int'(items.row) < mme_pkg::MAX_DIM) &&
                       (int'(items.col) < mme_pkg::MAX_DIM);
  assign wr_a        = accept && (items.op == mme_pkg::OP_WR_A) && in_store;
  assign wr_b        = accept && (items.op == mme_pkg::OP_WR_B) && in_store;
  assign comp_go     = accept && (items.op == mme_pkg::OP_COMPUTE) &&
                       ({1'b0, items.row} < mme_pkg::eff_size(a_rows));

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= mme_pkg::SIZE_RESET;
      k_size <= mme_pkg::SIZE_RESET;
      b_cols <= mme_pkg::SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mme_pkg::CFG_A_ROWS: a_rows <= cfg.data;
        mme_pkg::CFG_SHARED: k_size <= cfg.data;
        mme_pkg::CFG_B_COLS: b_cols <= cfg.data;
        default: ;
      endcase
    end
  end

  // left matrix store, read one element per cycle along the row
  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[mme_pkg::elem_addr(items.row, mme_pkg::SZ_W'(items.col))] <= items.value;
    end
    a_q <= a_mem[mme_pkg::elem_addr(row_q, kcnt)];
  end

  always_comb begin
    tok_next       = '0;
    tok_next.valid = (state == ST_RUN);
    tok_next.first = (kcnt == '0);
    tok_next.k     = mme_pkg::KW'(kcnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_next;
    end
  end

  // sequencer
  assign load     = (state == ST_DRAIN) && (!out_valid || results.ready);
  assign last_col = (dcnt == cols_q - mme_pkg::SZ_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kcnt  <= '0;
      wcnt  <= '0;
      dcnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (comp_go) begin
            state <= ST_RUN;
            kcnt  <= '0;
          end
        end
        ST_RUN: begin
          if (kcnt == kn_q - mme_pkg::SZ_W'(1)) begin
            state <= ST_WAIT;
            wcnt  <= '0;
          end else begin
            kcnt <= kcnt + mme_pkg::SZ_W'(1);
          end
        end
        ST_WAIT: begin
          if (wcnt == WW'(WAIT_LAST)) begin
            state <= ST_DRAIN;
            dcnt  <= '0;
          end else begin
            wcnt <= wcnt + WW'(1);
          end
        end
        ST_DRAIN: begin
          if (load) begin
            dcnt <= dcnt + mme_pkg::SZ_W'(1);
            if (last_col) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (comp_go) begin
      row_q  <= items.row;
      kn_q   <= mme_pkg::eff_size(k_size);
      cols_q <= mme_pkg::eff_size(b_cols);
    end
  end

  // chain of column cells
  for (genvar j = 0; j < mme_pkg::MAX_DIM; j++) begin : g_cell
    mme_pkg::mme_tok_t                 c_tok;
    logic signed [15:0]                c_a;
    logic signed [mme_pkg::ACC_W-1:0]  c_acc;

    if (j == 0) begin : g_head
      assign c_tok = tok_q;
      assign c_a   = a_q;
    end else begin : g_body
      assign c_tok = tok_o[j-1];
      assign c_a   = a_o[j-1];
    end

    if (j == mme_pkg::MAX_DIM - 1) begin : g_tail
      assign c_acc = '0;
    end else begin : g_link
      assign c_acc = acc_o[j+1];
    end

    mme_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_tok  (c_tok),
      .in_a    (c_a),
      .out_tok (tok_o[j]),
      .out_a   (a_o[j]),
      .b_we    (wr_b && (int'(items.col) == j)),
      .b_addr  (mme_pkg::KW'(items.row)),
      .b_data  (items.value),
      .shift   (load),
      .in_acc  (c_acc),
      .acc     (acc_o[j])
    );
  end

  // saturate the head cell's sum to 32 bits
  assign acc_hi = acc_o[0][mme_pkg::ACC_W-1:31];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      sat_sum  = acc_o[0][31:0];
      sat_clip = 1'b0;
    end else if (acc_hi[mme_pkg::ACC_W-32]) begin
      sat_sum  = 32'sh8000_0000;
      sat_clip = 1'b1;
    end else begin
      sat_sum  = 32'sh7fff_ffff;
      sat_clip = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_col  <= dcnt[3:0];
      out_sum  <= sat_sum;
      out_clip <= sat_clip;
      out_last <= last_col;
    end
  end

  assign results.valid   = out_valid;
  assign results.out_col = out_col;
  assign results.sum     = out_sum;
  assign results.clipped = out_clip;
  assign results.last    = out_last;

  // checks
  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (kcnt < kn_q))
    else $error("shared index beyond configured size");

  a_drain_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (dcnt < cols_q))
    else $error("drain column beyond configured count");

  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    comp_go |=> (state == ST_RUN))
    else $error("row compute request did not start");

  a_mid_row_beat: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && !results.last) |-> (state == ST_DRAIN))
    else $error("non-final beat taken outside drain");

endmodule
